// ===== hw/rtl/mkeq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the mouse/key event queue.
// No dependencies; every other file of the block imports it.
package mkeq_pkg;

    localparam int MKEQ_DEPTH = 128;

    localparam logic [7:0] CLICK_WINDOW_RST = 8'd50;
    localparam int LEVEL_W = 7;
    localparam int NUM_SRC = 8;

    // opcodes
    localparam logic [1:0] OP_POLL  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // config register indexes
    localparam logic CFG_MOUSE_EN  = 1'b0;
    localparam logic CFG_CLICK_WIN = 1'b1;

    // mouse event codes
    localparam logic [15:0] EV_LDOWN   = 16'd0;
    localparam logic [15:0] EV_LUP     = 16'd1;
    localparam logic [15:0] EV_LCLICK  = 16'd2;
    localparam logic [15:0] EV_RDOWN   = 16'd3;
    localparam logic [15:0] EV_RUP     = 16'd4;
    localparam logic [15:0] EV_RCLICK  = 16'd5;
    localparam logic [15:0] EV_LREPEAT = 16'd6;
    localparam logic [15:0] EV_RREPEAT = 16'd7;
    localparam logic [15:0] EV_MOVE    = 16'd8;

    // event sources of one poll, in queue order
    localparam logic [2:0] SRC_LEFT    = 3'd0;
    localparam logic [2:0] SRC_LCLICK  = 3'd1;
    localparam logic [2:0] SRC_RIGHT   = 3'd2;
    localparam logic [2:0] SRC_RCLICK  = 3'd3;
    localparam logic [2:0] SRC_LREPEAT = 3'd4;
    localparam logic [2:0] SRC_RREPEAT = 3'd5;
    localparam logic [2:0] SRC_MOVE    = 3'd6;
    localparam logic [2:0] SRC_KEY     = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  mouse_x;
        logic [9:0]  mouse_y;
        logic [1:0]  buttons;
        logic        key_ready;
        logic [15:0] key_code;
        logic [31:0] now_hsec;
    } t_in_word;

    typedef struct packed {
        logic        event_valid;
        logic        event_kind;
        logic [15:0] event_code;
        logic [9:0]  event_x;
        logic [9:0]  event_y;
        logic [2:0]  events_added;
        logic        key_taken;
        logic [6:0]  queue_level;
    } t_res_word;

    typedef struct packed {
        logic        kind;
        logic [15:0] code;
        logic [9:0]  x;
        logic [9:0]  y;
    } t_entry;

    typedef struct packed {
        logic load;
        logic decode;
        logic pop;
        logic clear;
        logic push;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] opcode;
        logic       empty;
        logic       pend_any;
        logic       out_free;
    } t_dp_sts;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH,
        ST_FINISH
    } t_state;

endpackage

// ===== hw/rtl/mkeq_cmd_if.sv =====
`timescale 1ns / 1ps
// Input channel of the event queue: valid/ready plus one command word.
// Depends on mkeq_pkg.
interface mkeq_cmd_if;
    import mkeq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mkeq_res_if.sv =====
`timescale 1ns / 1ps
// Output channel of the event queue: valid/ready plus one result word.
// Depends on mkeq_pkg.
interface mkeq_res_if;
    import mkeq_pkg::*;

    logic      valid;
    logic      ready;
    t_res_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mkeq_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the event queue: steps one command word through
// latch, execute, event pushes and result hand-off. Depends on mkeq_pkg.
module mkeq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mkeq_pkg::t_dp_sts i_sts,
    output mkeq_pkg::t_dp_cmd o_cmd
);
    import mkeq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_sts.opcode)
                    OP_POLL: begin
                        o_cmd.decode = 1'b1;
                        n_state      = ST_PUSH;
                    end
                    OP_POP: begin
                        o_cmd.pop = !i_sts.empty;
                        n_state   = ST_FINISH;
                    end
                    OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_FINISH;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_PUSH: begin
                // one queue write per cycle until no source is pending
                if (i_sts.pend_any) begin
                    o_cmd.push = 1'b1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mkeq_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the event queue: config registers, mouse tracking state,
// event store with pointers, and the output register. Depends on mkeq_pkg.
module mkeq_dp #(
    parameter int QUEUE_DEPTH = mkeq_pkg::MKEQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [7:0]          i_cfg_data,
    input  mkeq_pkg::t_in_word  i_in_data,
    input  mkeq_pkg::t_dp_cmd   i_cmd,
    output mkeq_pkg::t_dp_sts   o_sts,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output mkeq_pkg::t_res_word o_res_data
);
    import mkeq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = PTR_W + 1;

    // config
    logic       r_mouse_en;
    logic [7:0] r_click_win;

    // latched command word
    t_in_word r_in;

    // mouse state
    logic        r_left_held;
    logic        r_right_held;
    logic [31:0] r_left_dl;
    logic [31:0] r_right_dl;
    logic [9:0]  r_last_x;
    logic [9:0]  r_last_y;

    // poll work
    logic [NUM_SRC-1:0] r_pend;
    logic               r_lpress;
    logic               r_rpress;

    // queue
    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;

    // per-operation result fields
    t_entry     r_ev;
    logic       r_ev_vld;
    logic [2:0] r_added;
    logic       r_taken;

    t_res_word  r_out;
    logic       r_out_valid;

    // ---------------- combinational helpers ----------------
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_next;
    logic             full;
    logic             empty;
    logic [LVL_W-1:0] level;
    logic [LVL_W+LEVEL_W-1:0] level_ext;

    assign wp_next = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign full    = (wp_next == r_rp);
    assign empty   = (r_wp == r_rp);

    always_comb begin
        if (r_wp >= r_rp) begin
            level = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            level = {1'b0, r_wp} + LVL_W'(QUEUE_DEPTH) - {1'b0, r_rp};
        end
    end
    assign level_ext = {{LEVEL_W{1'b0}}, level};

    // poll decode
    logic        lb, rb;
    logic        lpress, lrel, rpress, rrel, changed, moved;
    logic [32:0] dl_sum;
    logic [31:0] deadline;
    logic [NUM_SRC-1:0] pend_dec;

    assign lb      = r_in.buttons[0];
    assign rb      = r_in.buttons[1];
    assign lpress  = r_mouse_en && !r_left_held && lb;
    assign lrel    = r_mouse_en && r_left_held && !lb;
    assign rpress  = r_mouse_en && !r_right_held && rb;
    assign rrel    = r_mouse_en && r_right_held && !rb;
    assign changed = lpress || lrel || rpress || rrel;
    assign moved   = (r_in.mouse_x != r_last_x) || (r_in.mouse_y != r_last_y);
    assign dl_sum  = {1'b0, r_in.now_hsec} + 33'(r_click_win);
    assign deadline = dl_sum[32] ? '1 : dl_sum[31:0];

    always_comb begin
        pend_dec = '0;
        if (r_mouse_en) begin
            pend_dec[SRC_LEFT]    = lpress || lrel;
            pend_dec[SRC_LCLICK]  = lrel && (r_in.now_hsec < r_left_dl);
            pend_dec[SRC_RIGHT]   = rpress || rrel;
            pend_dec[SRC_RCLICK]  = rrel && (r_in.now_hsec < r_right_dl);
            pend_dec[SRC_LREPEAT] = !changed && r_left_held && (r_in.now_hsec > r_left_dl);
            pend_dec[SRC_RREPEAT] = !changed && r_right_held && (r_in.now_hsec > r_right_dl);
            pend_dec[SRC_MOVE]    = !changed && (r_left_held || r_right_held) && moved;
        end
        pend_dec[SRC_KEY] = r_in.key_ready;
    end

    // lowest pending source goes next
    logic [2:0]         src;
    logic [NUM_SRC-1:0] src_bit;
    t_entry             push_ent;

    always_comb begin
        src = SRC_KEY;
        for (int i = NUM_SRC - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                src = 3'(i);
            end
        end
        src_bit = NUM_SRC'(1) << src;
    end

    always_comb begin
        push_ent.kind = 1'b0;
        push_ent.x    = r_in.mouse_x;
        push_ent.y    = r_in.mouse_y;
        case (src)
            SRC_LEFT:    push_ent.code = r_lpress ? EV_LDOWN : EV_LUP;
            SRC_LCLICK:  push_ent.code = EV_LCLICK;
            SRC_RIGHT:   push_ent.code = r_rpress ? EV_RDOWN : EV_RUP;
            SRC_RCLICK:  push_ent.code = EV_RCLICK;
            SRC_LREPEAT: push_ent.code = EV_LREPEAT;
            SRC_RREPEAT: push_ent.code = EV_RREPEAT;
            SRC_MOVE:    push_ent.code = EV_MOVE;
            default: begin
                push_ent.kind = 1'b1;
                push_ent.code = r_in.key_code;
                push_ent.x    = '0;
                push_ent.y    = '0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mouse_en  <= 1'b0;
            r_click_win <= CLICK_WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOUSE_EN:  r_mouse_en  <= i_cfg_data[0];
                CFG_CLICK_WIN: r_click_win <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_held  <= 1'b0;
            r_right_held <= 1'b0;
            r_left_dl    <= '1;
            r_right_dl   <= '1;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_pend       <= '0;
            r_lpress     <= 1'b0;
            r_rpress     <= 1'b0;
        end else if (i_cmd.decode) begin
            r_pend   <= pend_dec;
            r_lpress <= lpress;
            r_rpress <= rpress;
            if (r_mouse_en) begin
                r_last_x     <= r_in.mouse_x;
                r_last_y     <= r_in.mouse_y;
                r_left_held  <= lb;
                r_right_held <= rb;
                if (lpress) begin
                    r_left_dl <= deadline;
                end
                if (rpress) begin
                    r_right_dl <= deadline;
                end
            end
        end else if (i_cmd.push) begin
            r_pend <= r_pend & ~src_bit;
        end
    end

    // event store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !full) begin
            r_mem[r_wp] <= push_ent;
        end
        r_rd_data <= r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_cmd.push && !full) begin
                r_wp <= wp_next;
            end else if (i_cmd.clear) begin
                r_wp <= r_rp;
            end
            if (i_cmd.pop) begin
                r_rp <= rp_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ev     <= '0;
            r_ev_vld <= 1'b0;
            r_added  <= '0;
            r_taken  <= 1'b0;
        end else if (i_cmd.pop) begin
            r_ev     <= r_rd_data;
            r_ev_vld <= 1'b1;
        end else if (i_cmd.push && !full) begin
            r_added <= r_added + 3'd1;
            if (src == SRC_KEY) begin
                r_taken <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.event_valid  <= r_ev_vld;
            r_out.event_kind   <= r_ev.kind;
            r_out.event_code   <= r_ev.code;
            r_out.event_x      <= r_ev.x;
            r_out.event_y      <= r_ev.y;
            r_out.events_added <= r_added;
            r_out.key_taken    <= r_taken;
            r_out.queue_level  <= level_ext[LEVEL_W-1:0];
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_res_data     = r_out;
    assign o_sts.opcode   = r_in.opcode;
    assign o_sts.empty    = empty;
    assign o_sts.pend_any = |r_pend;
    assign o_sts.out_free = !r_out_valid || i_res_ready;

endmodule

// ===== hw/rtl/mouse_key_event_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the mouse/key event queue: sequencer plus datapath.
// Depends on mkeq_pkg, mkeq_cmd_if, mkeq_res_if, mkeq_ctrl, mkeq_dp.
//
// One command word in, one result word out. A poll word compares the
// sampled pointer position and two buttons with the tracked state and
// writes up to five events (button down/up, click, repeat, move, key)
// into a FIFO of QUEUE_DEPTH entries, of which QUEUE_DEPTH-1 are usable;
// a write to a full queue is dropped and a waiting key is then not taken.
// A pop word returns the oldest event, a clear word empties the queue.
// Timing: words are handled one at a time. A poll goes through latch,
// execute, one push per pending event (at most 5, dropped ones included;
// the event store has one write port, so events go in one per cycle) and
// the result step; pop, clear and the unused opcode skip the pushes.
// A result that the receiver has not yet taken holds the sequencer in
// its last step. The next word can be accepted in the same cycle as the
// previous result sits in the output register, even if not yet taken.
// Config writes (index 0 mouse enable, index 1 click window in
// hundredths) are registered and are meant for idle periods.
// The event store needs no clearing after reset: it is never read
// beyond the write pointer.
module mouse_key_event_queue_core #(
    parameter int QUEUE_DEPTH = mkeq_pkg::MKEQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mkeq_cmd_if.sink    i_cmd,
    mkeq_res_if.source  o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import mkeq_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mkeq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mkeq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_cmd.data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res_data  (o_res.data)
    );

endmodule

// ===== hw/rtl/mkeq_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker of the event queue, bound to the top level.
// Depends on mkeq_pkg and mouse_key_event_queue_core.
module mkeq_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input mkeq_pkg::t_res_word i_out_data
);
    import mkeq_pkg::*;

    // no result word right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one word in flight: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready held after accept");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // no event fields without an event
    a_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.event_valid |->
            i_out_data.event_kind == 1'b0 && i_out_data.event_code == 16'd0 &&
            i_out_data.event_x == 10'd0 && i_out_data.event_y == 10'd0)
        else $error("event fields set without event");

    // a taken key is counted, and a poll writes at most five events
    a_added_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_out_data.events_added <= 3'd5 &&
            (!i_out_data.key_taken || i_out_data.events_added != 3'd0))
        else $error("bad events_added or key_taken");

endmodule

bind mouse_key_event_queue_core mkeq_chk u_mkeq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
